>>> src/wss_pkg.sv
package wss_pkg;

  // Stage codes, as reported on stage_now
  localparam logic [2:0] StReady    = 3'd0;
  localparam logic [2:0] StPicker   = 3'd1;
  localparam logic [2:0] StRelease  = 3'd2;
  localparam logic [2:0] StWinch    = 3'd3;
  localparam logic [2:0] StLock     = 3'd4;
  localparam logic [2:0] StReverse  = 3'd5;
  localparam logic [2:0] StOverride = 3'd6;

  // Motor commands
  localparam logic signed [1:0] MotorRev = -2'sd1;
  localparam logic signed [1:0] MotorOff = 2'sd0;
  localparam logic signed [1:0] MotorFwd = 2'sd1;

  // Configuration register indexes
  localparam logic [2:0] RegReleaseDelay  = 3'd0;
  localparam logic [2:0] RegWinchTimeout  = 3'd1;
  localparam logic [2:0] RegLockDelay     = 3'd2;
  localparam logic [2:0] RegReverseTimeout = 3'd3;
  localparam logic [2:0] RegReverseLimit  = 3'd4;

  // Configuration reset values
  localparam logic [7:0]         RstReleaseDelay   = 8'd25;
  localparam logic [7:0]         RstWinchTimeout   = 8'd100;
  localparam logic [7:0]         RstLockDelay      = 8'd5;
  localparam logic [7:0]         RstReverseTimeout = 8'd50;
  localparam logic signed [15:0] RstReverseLimit   = -16'sd1400;

endpackage

>>> src/winch_shooter_sequencer.sv
// An accepted input item has its result item on the output register from the next cycle.
// Throughput: one item per cycle while results are taken; the output register frees itself
// in the same cycle it is taken, so the next item is accepted as a result is delivered.
// Reset (rst_ni low, asynchronous): stage ready, counter zero, motor off, latch locked,
// configuration back to its defaults, no result pending.
module winch_shooter_sequencer
  import wss_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  // input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               shoot_button_i,
  input  logic               shoot_request_i,
  input  logic               winch_down_held_i,
  input  logic               winch_up_held_i,
  input  logic               limit_down_i,
  input  logic               picker_is_down_i,
  input  logic signed [15:0] encoder_count_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [1:0]  motor_drive_o,
  output logic               latch_released_o,
  output logic               picker_drop_request_o,
  output logic               encoder_clear_o,
  output logic [2:0]         stage_now_o
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [7:0]         release_delay_q;
  logic [7:0]         winch_timeout_q;
  logic [7:0]         lock_delay_q;
  logic [7:0]         reverse_timeout_q;
  logic signed [15:0] reverse_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      release_delay_q   <= RstReleaseDelay;
      winch_timeout_q   <= RstWinchTimeout;
      lock_delay_q      <= RstLockDelay;
      reverse_timeout_q <= RstReverseTimeout;
      reverse_limit_q   <= RstReverseLimit;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegReleaseDelay:   release_delay_q   <= cfg_data_i[7:0];
        RegWinchTimeout:   winch_timeout_q   <= cfg_data_i[7:0];
        RegLockDelay:      lock_delay_q      <= cfg_data_i[7:0];
        RegReverseTimeout: reverse_timeout_q <= cfg_data_i[7:0];
        RegReverseLimit:   reverse_limit_q   <= cfg_data_i;
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: the output register is free when empty or being taken now
  // ---------------------------------------------------------------------------
  logic out_valid_q;
  logic in_fire;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  logic [2:0]        stage_q, stage_d;
  logic [7:0]        tick_q, tick_d;
  logic signed [1:0] motor_q, motor_d;
  logic              latch_q, latch_d;
  logic              pick_req_d;
  logic              clear_d;

  // Per-tick decision. Override is applied first; the stage case then sees the
  // stage it leaves behind, so an override tick never runs sequence logic.
  always_comb begin
    stage_d    = stage_q;
    tick_d     = tick_q;
    motor_d    = motor_q;
    latch_d    = latch_q;
    pick_req_d = 1'b0;
    clear_d    = 1'b0;

    if (winch_down_held_i) begin
      motor_d = MotorFwd;
      if (limit_down_i) begin
        latch_d = 1'b0;
      end
      stage_d = StOverride;
    end else if (winch_up_held_i) begin
      motor_d = MotorRev;
      stage_d = StOverride;
    end

    unique case (stage_d)
      StReady, StPicker: begin
        if (shoot_button_i || shoot_request_i || stage_d == StPicker) begin
          if (!picker_is_down_i) begin
            pick_req_d = 1'b1;
            stage_d    = StPicker;
          end else begin
            latch_d = 1'b1;
            tick_d  = release_delay_q;
            stage_d = StRelease;
          end
        end
      end
      StRelease: begin
        if (tick_d != 8'd0) begin
          tick_d = tick_d - 8'd1;
        end
        if (tick_d == 8'd0) begin
          tick_d  = winch_timeout_q;
          stage_d = StWinch;
        end
      end
      StWinch: begin
        if (tick_d != 8'd0) begin
          motor_d = MotorFwd;
          // limit switch cuts the draw short
          tick_d  = limit_down_i ? 8'd0 : tick_d - 8'd1;
        end
        if (tick_d == 8'd0) begin
          latch_d = 1'b0;
          tick_d  = lock_delay_q;
          stage_d = StLock;
        end
      end
      StLock: begin
        if (tick_d != 8'd0) begin
          tick_d = tick_d - 8'd1;
        end
        if (tick_d == 8'd0) begin
          motor_d = MotorOff;
          clear_d = 1'b1;
          tick_d  = reverse_timeout_q;
          stage_d = StReverse;
        end
      end
      StReverse: begin
        if (tick_d != 8'd0) begin
          motor_d = MotorRev;
          tick_d  = tick_d - 8'd1;
          // far enough back: stop early
          if (encoder_count_i < reverse_limit_q) begin
            tick_d = 8'd0;
          end
        end
        if (tick_d == 8'd0) begin
          motor_d = MotorOff;
          clear_d = 1'b1;
          stage_d = StReady;
        end
      end
      StOverride: begin
        if (!winch_down_held_i && !winch_up_held_i) begin
          motor_d = MotorOff;
          clear_d = 1'b1;
          tick_d  = 8'd0;
          stage_d = StReady;
        end
      end
      default: ;  // unused stage code: tick changes nothing
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= StReady;
      tick_q  <= 8'd0;
      motor_q <= MotorOff;
      latch_q <= 1'b0;
    end else if (in_fire) begin
      stage_q <= stage_d;
      tick_q  <= tick_d;
      motor_q <= motor_d;
      latch_q <= latch_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      motor_drive_o         <= motor_d;
      latch_released_o      <= latch_d;
      picker_drop_request_o <= pick_req_d;
      encoder_clear_o       <= clear_d;
      stage_now_o           <= stage_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> src/wss_checker.sv
module wss_checker
  import wss_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [1:0]  motor_drive_o,
  input logic               picker_drop_request_o,
  input logic               encoder_clear_o,
  input logic [2:0]         stage_now_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(stage_now_o)
      && $stable(motor_drive_o) && $stable(encoder_clear_o))
    else $error("stalled result changed");

  // empty output register must take an item
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with output register empty");

  // encoder clear only on entry to reverse or return to ready, with motor off
  a_clear_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && encoder_clear_o |->
      motor_drive_o == MotorOff && (stage_now_o == StReady || stage_now_o == StReverse))
    else $error("encoder clear outside stage change");

  // picker request only while waiting for the picker, motor off
  a_pick_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && picker_drop_request_o |->
      stage_now_o == StPicker && motor_drive_o == MotorOff)
    else $error("picker request outside picker stage");

endmodule

bind winch_shooter_sequencer wss_checker u_wss_checker (.*);
